[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// plain property check
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_PROP(lbl, prop)
`define ASSERT_IMPL(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/core/trk_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trk_pkg
// shared constants and types of the pattern line decoder
// ----------------------------------------------------------------------------
package trk_pkg;

  localparam int LINES_PER_PATTERN = 64;
  localparam int CNT_W = $clog2(LINES_PER_PATTERN);

  // line record queue depth, a power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CODE_EMPTY = 8'h00;
  localparam logic [7:0] CODE_REST  = 8'h80;
  localparam logic [7:0] CODE_TEMPO = 8'h81;
  localparam logic [7:0] CODE_END   = 8'h82;

  localparam logic [2:0] EV_LINE  = 3'd0;
  localparam logic [2:0] EV_REST  = 3'd1;
  localparam logic [2:0] EV_TEMPO = 3'd2;
  localparam logic [2:0] EV_NOTE  = 3'd3;
  localparam logic [2:0] EV_END   = 3'd4;
  localparam logic [2:0] EV_UNK   = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] chan;
    logic [7:0] value;
    logic [7:0] sample;
  } trk_ev_t;

  // one decoded line: line start plus nch channel events, compacted
  typedef struct packed {
    logic [5:0]      line;
    logic [1:0]      nch;
    trk_ev_t [2:0]   ev;
  } trk_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } trk_qstat_t;

endpackage
`default_nettype wire

[rtl/core/trk_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trk_if
// valid/ready channels for pattern lines and decoded events
// ----------------------------------------------------------------------------
interface trk_line_if;
  logic       valid;
  logic       ready;
  logic       restart;
  logic [7:0] note_ch0;
  logic [7:0] sample_ch0;
  logic [7:0] note_ch1;
  logic [7:0] sample_ch1;
  logic [7:0] note_ch2;
  logic [7:0] sample_ch2;

  modport source (
    output valid, restart, note_ch0, sample_ch0, note_ch1, sample_ch1,
           note_ch2, sample_ch2,
    input  ready
  );
  modport sink (
    input  valid, restart, note_ch0, sample_ch0, note_ch1, sample_ch1,
           note_ch2, sample_ch2,
    output ready
  );
endinterface

interface trk_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [5:0] line_number;
  logic [1:0] channel;
  logic [7:0] value;
  logic [7:0] sample;
  logic       last;

  modport source (
    output valid, event_kind, line_number, channel, value, sample, last,
    input  ready
  );
  modport sink (
    input  valid, event_kind, line_number, channel, value, sample, last,
    output ready
  );
endinterface
`default_nettype wire

[rtl/core/trk_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trk_front
// takes pattern lines, tracks line count and pattern end, builds line records
// ----------------------------------------------------------------------------
module trk_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  trk_line_if.sink                 in_line,
  input  wire trk_pkg::trk_qstat_t qstat,
  output logic                     push,
  output trk_pkg::trk_rec_t        push_rec
);
  import trk_pkg::*;

  localparam logic [CNT_W-1:0] LAST_LINE = CNT_W'(LINES_PER_PATTERN - 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ended_r, ended_nxt;

  logic [CNT_W-1:0] lc;
  logic             pe;
  logic             final_line;
  logic             active;
  logic             take;
  logic             stop;
  logic [1:0]       n;
  logic [7:0]       note [3];
  logic [7:0]       samp [3];
  trk_ev_t          ev;
  trk_rec_t         rec;

  assign note[0] = in_line.note_ch0;
  assign note[1] = in_line.note_ch1;
  assign note[2] = in_line.note_ch2;
  assign samp[0] = in_line.sample_ch0;
  assign samp[1] = in_line.sample_ch1;
  assign samp[2] = in_line.sample_ch2;

  assign in_line.ready = !qstat.full;
  assign take          = in_line.valid && !qstat.full;

  // restart applies before the line is decoded
  assign lc         = in_line.restart ? '0 : cnt_r;
  assign pe         = in_line.restart ? 1'b0 : ended_r;
  assign final_line = (lc == LAST_LINE);
  assign active     = !pe && (final_line || note[0] != CODE_EMPTY ||
                      note[1] != CODE_EMPTY || note[2] != CODE_EMPTY);

  always_comb begin
    rec      = '0;
    rec.line = 6'(lc);
    stop     = 1'b0;
    n        = 2'd0;
    ev       = '0;
    for (int i = 0; i < 3; i++) begin
      if (!stop && note[i] != CODE_EMPTY) begin
        ev      = '0;
        ev.chan = 2'(i);
        case (note[i])
          CODE_REST: begin
            ev.kind = EV_REST;
          end
          CODE_TEMPO: begin
            ev.kind  = EV_TEMPO;
            ev.value = samp[i];
          end
          CODE_END: begin
            ev.kind = EV_END;
            stop    = 1'b1;
          end
          default: begin
            if (note[i] > CODE_END) begin
              ev.kind = EV_UNK;
            end else begin
              ev.kind   = EV_NOTE;
              ev.value  = note[i] - 8'd1;
              ev.sample = samp[i];
            end
          end
        endcase
        rec.ev[n] = ev;
        n         = n + 2'd1;
      end
    end
    rec.nch = n;
  end

  always_comb begin
    if (final_line) begin
      cnt_nxt   = '0;
      ended_nxt = 1'b0;
    end else begin
      cnt_nxt   = lc + 1'b1;
      ended_nxt = pe || (active && stop);
    end
  end

  assign push     = take && active;
  assign push_rec = rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      ended_r <= 1'b0;
    end else if (take) begin
      cnt_r   <= cnt_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/trk_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trk_queue
// short fifo of line records between the front and the back
// ----------------------------------------------------------------------------
module trk_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire trk_pkg::trk_rec_t push_rec,
  input  wire logic              pop,
  output trk_pkg::trk_rec_t      head_rec,
  output trk_pkg::trk_qstat_t    qstat
);
  import trk_pkg::*;

  trk_rec_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]  rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign qstat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head_rec    = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/trk_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// trk_back
// plays out the head line record one event per cycle while out_ev is ready
// ----------------------------------------------------------------------------
module trk_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire trk_pkg::trk_rec_t   head_rec,
  input  wire trk_pkg::trk_qstat_t qstat,
  output logic                     pop,
  trk_event_if.source              out_ev
);
  import trk_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       is_last;
  logic       xfer;
  trk_ev_t    cur;

  // index zero is the line start, index k is channel event k-1
  assign cur     = head_rec.ev[idx_r - 2'd1];
  assign is_last = (idx_r == head_rec.nch);
  assign xfer    = out_ev.valid && out_ev.ready;
  assign pop     = xfer && is_last;

  assign out_ev.valid       = !qstat.empty;
  assign out_ev.line_number = head_rec.line;
  assign out_ev.last        = is_last;

  always_comb begin
    if (idx_r == 2'd0) begin
      out_ev.event_kind = EV_LINE;
      out_ev.channel    = 2'd0;
      out_ev.value      = 8'd0;
      out_ev.sample     = 8'd0;
    end else begin
      out_ev.event_kind = cur.kind;
      out_ev.channel    = cur.chan;
      out_ev.value      = cur.value;
      out_ev.sample     = cur.sample;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (xfer) begin
      idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/tracker_pattern_line_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tracker_pattern_line_decoder
// Turns three-channel pattern lines into line-start and channel events. A
// line is taken whenever the two-entry record queue has room, and each line
// gives up to four events, one per cycle while the output is ready: a line
// start followed by its channel events. Empty lines other than the last
// line of the pattern, and lines after a pattern end, are consumed with no
// output. The event output runs at one transfer per cycle while out_ev is
// ready, set by the back end stepping through the head record.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tracker_pattern_line_decoder (
  input  wire logic   clk,
  input  wire logic   rst_n,
  trk_line_if.sink    in_line,
  trk_event_if.source out_ev
);
  import trk_pkg::*;

  logic       push;
  trk_rec_t   push_rec;
  logic       pop;
  trk_rec_t   head_rec;
  trk_qstat_t qstat;
  logic       ev_xfer;

  trk_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_line  (in_line),
    .qstat    (qstat),
    .push     (push),
    .push_rec (push_rec)
  );

  trk_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .qstat    (qstat)
  );

  trk_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_rec (head_rec),
    .qstat    (qstat),
    .pop      (pop),
    .out_ev   (out_ev)
  );

  assign ev_xfer = out_ev.valid && out_ev.ready;

  // a transfer that is not the last of its line is followed by a channel event
  `ASSERT_NEXT(a_cont_no_line, ev_xfer && !out_ev.last, out_ev.valid && out_ev.event_kind != EV_LINE)
  // pattern end closes its line
  `ASSERT_IMPL(a_end_is_last, out_ev.valid && out_ev.event_kind == EV_END, out_ev.last)
  // a full queue stalls the input
  `ASSERT_IMPL(a_full_stalls, qstat.full, !in_line.ready)
  // events pending whenever the queue holds a record
  `ASSERT_PROP(a_valid_match, out_ev.valid == !qstat.empty)

endmodule
`default_nettype wire
